@@ rtl/core/cts_pkg.sv @@
// Shared types, constants and helper functions of the token splitter.
`timescale 1ns / 1ps
package cts_pkg;

	// Window geometry
	localparam int WINDOW = 64;
	localparam int AW     = $clog2(WINDOW);
	localparam int CW     = AW + 1;

	// Token limit clamp bounds
	localparam logic [6:0] LIMIT_MAX   = 7'd65;
	localparam logic [6:0] LIMIT_MIN   = 7'd2;
	localparam logic [6:0] LIMIT_RESET = 7'd65;

	// Character codes
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_LBRK  = 8'h5B;
	localparam logic [7:0] CH_RBRK  = 8'h5D;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_QUOTE = 8'h27;
	localparam logic [7:0] CH_S     = 8'h73;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_D     = 8'h64;
	localparam logic [7:0] CH_L     = 8'h6C;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;    // write one input beat into the window
		logic decide;  // register the token decision
		logic fetch;   // read the window at the emit index
		logic push;    // load one token beat into the output register
	} cts_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic out_free;  // output register can take a beat this cycle
		logic tok_done;  // emit index points at the final token byte
	} cts_status_t;

	// Size of a UTF-8 character from its lead byte; invalid lead gives one
	function automatic logic [2:0] utf8_lead_size(input logic [7:0] b);
		logic [2:0] n;
		if (b[7] == 1'b0) n = 3'd1;
		else if (b[7:5] == 3'b110) n = 3'd2;
		else if (b[7:4] == 4'b1110) n = 3'd3;
		else if (b[7:3] == 5'b11110) n = 3'd4;
		else n = 3'd1;
		return n;
	endfunction

	// Byte that a backslash escape stands for; valid is low for unknown escapes
	function automatic logic [8:0] escape_map(input logic [7:0] e);
		logic [8:0] r;
		case (e)
			CH_S:    r = {1'b1, CH_SPACE};
			CH_T:    r = {1'b1, CH_TAB};
			CH_N:    r = {1'b1, CH_LF};
			CH_R:    r = {1'b1, CH_CR};
			CH_BSL:  r = {1'b1, CH_BSL};
			default: r = {1'b0, CH_BSL};
		endcase
		return r;
	endfunction

endpackage

@@ rtl/core/cts_ctrl.sv @@
// Controller state machine: loading, decision, and byte-wise token emit.
`timescale 1ns / 1ps
module cts_ctrl
	import cts_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_last,
	output logic        in_ready,
	input  cts_status_t st,
	output cts_cmd_t    cmd
);

	typedef enum logic [1:0] {
		S_LOAD,
		S_DECIDE,
		S_FETCH,
		S_PUSH
	} state_t;

	state_t state_q;

	// Decode commands from the current state
	always_comb begin
		in_ready    = (state_q == S_LOAD);
		cmd.load    = (state_q == S_LOAD) && in_valid;
		cmd.decide  = (state_q == S_DECIDE);
		cmd.fetch   = (state_q == S_FETCH);
		cmd.push    = (state_q == S_PUSH) && st.out_free;
	end

	// Advance the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (in_valid && in_last) state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					state_q <= S_FETCH;
				end
				S_FETCH: begin
					state_q <= S_PUSH;
				end
				S_PUSH: begin
					if (st.out_free) state_q <= st.tok_done ? S_LOAD : S_FETCH;
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	// Final beat of a token returns to loading
	a_done_to_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PUSH && st.out_free && st.tok_done) |=> (state_q == S_LOAD))
		else $error("token end did not return to loading");

	// A closing input beat always leads to a decision
	a_last_to_decide: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load && in_last) |=> (state_q == S_DECIDE))
		else $error("last beat did not start a decision");

	// No input is taken while a token is in flight
	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.decide || cmd.fetch || state_q == S_PUSH) |-> !in_ready)
		else $error("input ready while emitting");

endmodule

@@ rtl/core/cts_dpath.sv @@
// Datapath: window memory, group-mark tracking, token decision and output register.
`timescale 1ns / 1ps
module cts_dpath
	import cts_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [6:0]  cfg_wdata,
	input  logic [7:0]  in_byte,
	input  cts_cmd_t    cmd,
	output cts_status_t st,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  tok_byte,
	output logic        tok_last,
	output logic [6:0]  consumed
);

	logic [7:0]    mem [WINDOW];
	logic [CW-1:0] count_q;
	logic [7:0]    b0_q;
	logic [7:0]    b1_q;
	logic [CW-1:0] gt_len_q;
	logic [CW-1:0] rb_len_q;
	logic [6:0]    limit_q;
	logic [CW-1:0] tlen_q;
	logic [6:0]    used_q;
	logic          lit_q;
	logic [7:0]    lit_byte_q;
	logic [AW-1:0] k_q;
	logic [7:0]    rd_q;
	logic          out_valid_q;
	logic [7:0]    tok_byte_q;
	logic          tok_last_q;
	logic [6:0]    consumed_q;

	logic          wr_en;
	logic [CW-1:0] tlen_d;
	logic [6:0]    used_d;
	logic          lit_d;
	logic [7:0]    lit_byte_d;
	logic          last_beat;

	assign wr_en = cmd.load && (count_q < CW'(WINDOW));

	// Hold the token limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	// Write the window memory; bytes past a full window are dropped
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[count_q[AW-1:0]] <= in_byte;
		end
	end

	// Read the window at the emit index
	always_ff @(posedge clk) begin
		if (cmd.fetch) begin
			rd_q <= mem[k_q];
		end
	end

	// Capture the first two bytes while loading
	always_ff @(posedge clk) begin
		if (wr_en && count_q == '0) b0_q <= in_byte;
		if (wr_en && count_q == CW'(1)) b1_q <= in_byte;
	end

	// Track fill count and first closing marks past the opening byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			gt_len_q <= '0;
			rb_len_q <= '0;
		end else if (cmd.push && st.tok_done) begin
			count_q  <= '0;
			gt_len_q <= '0;
			rb_len_q <= '0;
		end else if (wr_en) begin
			count_q <= count_q + CW'(1);
			if (count_q != '0 && gt_len_q == '0 && in_byte == CH_GT)
				gt_len_q <= count_q + CW'(1);
			if (count_q != '0 && rb_len_q == '0 && in_byte == CH_RBRK)
				rb_len_q <= count_q + CW'(1);
		end
	end

	// Choose the token kind, its length and the bytes consumed
	always_comb begin
		logic [6:0]    lim;
		logic [CW-1:0] g;
		logic          grp_ok;
		logic [8:0]    esc;
		logic [6:0]    n;
		lim = limit_q;
		if (lim > LIMIT_MAX) lim = LIMIT_MAX;
		if (lim < LIMIT_MIN) lim = LIMIT_MIN;
		g = (b0_q == CH_LT) ? gt_len_q : (b0_q == CH_LBRK) ? rb_len_q : '0;
		grp_ok = (g != '0) && (7'(g) < lim);
		esc = escape_map(b1_q);
		n = 7'(utf8_lead_size(b0_q));
		if (n > 7'(count_q)) n = 7'(count_q);
		if (n >= lim) n = lim - 7'd1;
		lit_byte_d = esc[7:0];
		if (grp_ok) begin
			tlen_d = g;
			used_d = 7'(g);
			lit_d  = 1'b0;
		end else if (count_q > CW'(1) && b0_q == CH_BSL) begin
			tlen_d = CW'(1);
			used_d = esc[8] ? 7'd2 : 7'd1;
			lit_d  = 1'b1;
		end else if (count_q > CW'(1) && b0_q == CH_QUOTE && lim > 7'd2 &&
			(b1_q == CH_R || b1_q == CH_D || b1_q == CH_L || b1_q == CH_S)) begin
			tlen_d = CW'(2);
			used_d = 7'd2;
			lit_d  = 1'b0;
		end else begin
			tlen_d = CW'(n);
			used_d = n;
			lit_d  = 1'b0;
		end
	end

	// Register the decision
	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			tlen_q     <= tlen_d;
			used_q     <= used_d;
			lit_q      <= lit_d;
			lit_byte_q <= lit_byte_d;
		end
	end

	// Step the emit index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
		end else if (cmd.decide) begin
			k_q <= '0;
		end else if (cmd.push) begin
			k_q <= k_q + AW'(1);
		end
	end

	assign last_beat   = ({1'b0, k_q} + CW'(1)) == tlen_q;
	assign st.out_free = !out_valid_q || out_ready;
	assign st.tok_done = last_beat;

	// Load the output register; drop the beat once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			tok_byte_q <= lit_q ? lit_byte_q : rd_q;
			tok_last_q <= last_beat;
			consumed_q <= last_beat ? used_q : 7'd0;
		end
	end

	assign out_valid = out_valid_q;
	assign tok_byte  = tok_byte_q;
	assign tok_last  = tok_last_q;
	assign consumed  = consumed_q;

	// A push never overwrites a beat still waiting
	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> (!out_valid_q || out_ready))
		else $error("output beat overwritten");

	// Fill count stays within the window
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(WINDOW))
		else $error("fill count beyond window");

	// A decision always yields a nonempty token that fits the window
	a_tlen_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.decide && count_q != '0) |=>
		(tlen_q != '0 && tlen_q <= CW'(WINDOW) && used_q != 7'd0))
		else $error("token length out of range");

endmodule

@@ rtl/core/charset_token_splitter_core.sv @@
// Top level of the token splitter: controller and datapath.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+----------------------------
//  config    | cfg_we                    | cfg_wdata (token_limit)
//  input     | in_valid / in_ready       | in_byte, in_last
//  output    | out_valid / out_ready     | tok_byte, tok_last, consumed
//
// Loading takes one input beat per cycle into a 64-byte window memory.
// A beat with in_last leads to a decision state, then each token byte is
// a window memory read followed by a load of the output register.
// Input is held off from the closing beat until the final token byte is pushed.
// A stalled output holds the emit sequence in place; reset empties the window
// and sets token_limit to 65.
`timescale 1ns / 1ps
module charset_token_splitter_core
	import cts_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [6:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] tok_byte,
	output logic       tok_last,
	output logic [6:0] consumed
);

	cts_cmd_t    cmd;
	cts_status_t st;

	cts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_last  (in_last),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	cts_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_byte   (in_byte),
		.cmd       (cmd),
		.st        (st),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.tok_byte  (tok_byte),
		.tok_last  (tok_last),
		.consumed  (consumed)
	);

endmodule

@@ tb/tb_charset_token_splitter_core.sv @@
// Self-checking testbench for the charset token splitter core.
`timescale 1ns / 1ps
module tb_charset_token_splitter_core;
	import cts_pkg::*;

	localparam int CLK_PERIOD      = 4;
	localparam int RESET_CYCLES    = 5;
	localparam int PHASE_COUNT     = 8;
	localparam int PHASE_ITEMS     = 30;
	localparam int DRAIN_CYCLES    = 8;
	localparam int TAIL_CYCLES     = 40;
	localparam int PRESSURE_CYCLES = 400;
	localparam int PRESSURE_PHASE  = 4;
	localparam int LONG_PHASE      = 6;
	localparam int TIMEOUT_NS      = 2_000_000;

	typedef logic [7:0] text_t[$];

	typedef struct {
		logic [7:0] tok_byte;
		logic       tok_last;
		logic [6:0] consumed;
	} tok_beat_t;

	// Window model, token split and expected-beat store
	class token_scoreboard;
		logic [7:0]  window_bytes [WINDOW];
		int unsigned held;
		logic [6:0]  limit_reg;
		tok_beat_t   expected_beats[$];
		int          errors;

		function new();
			held      = 0;
			limit_reg = LIMIT_RESET;
			errors    = 0;
		endfunction

		function void set_limit(input logic [6:0] v);
			limit_reg = v;
		endfunction

		function int pending();
			return expected_beats.size();
		endfunction

		task report_mismatch(input string msg);
			$display("MISMATCH at %0t ns: %s", $time, msg);
			errors++;
		endtask

		function int unsigned lead_size(input logic [7:0] b);
			int unsigned n;
			casez (b)
				8'b0???????: n = 1;
				8'b110?????: n = 2;
				8'b1110????: n = 3;
				8'b11110???: n = 4;
				default:     n = 1;
			endcase
			return n;
		endfunction

		// Split one token off the front of the window and queue its beats
		function void split_token();
			logic [7:0]  tok[$];
			logic [7:0]  b0, close_mark, esc;
			int unsigned lim, grp, used, n;
			tok_beat_t   beat;
			lim = 32'(limit_reg);
			if (lim > 32'(LIMIT_MAX)) lim = 32'(LIMIT_MAX);
			if (lim < 32'(LIMIT_MIN)) lim = 32'(LIMIT_MIN);
			b0   = window_bytes[0];
			grp  = 0;
			used = 0;
			// bracketed group, only if the closing mark fits the limit
			if (b0 == CH_LT || b0 == CH_LBRK) begin
				close_mark = (b0 == CH_LT) ? CH_GT : CH_RBRK;
				for (int i = 1; i < held; i++)
					if (grp == 0 && window_bytes[i] == close_mark) grp = i + 1;
				if (grp > 0 && grp < lim) begin
					for (int i = 0; i < grp; i++) tok.push_back(window_bytes[i]);
					used = grp;
				end
			end
			// backslash escape
			if (tok.size() == 0 && held > 1 && b0 == CH_BSL) begin
				esc  = window_bytes[1];
				used = 2;
				case (esc)
					CH_S:    tok.push_back(CH_SPACE);
					CH_T:    tok.push_back(CH_TAB);
					CH_N:    tok.push_back(CH_LF);
					CH_R:    tok.push_back(CH_CR);
					CH_BSL:  tok.push_back(CH_BSL);
					default: begin
						tok.push_back(CH_BSL);
						used = 1;
					end
				endcase
			end
			// quote pair
			if (tok.size() == 0 && held > 1 && b0 == CH_QUOTE && lim > 2) begin
				esc = window_bytes[1];
				if (esc == CH_R || esc == CH_D || esc == CH_L || esc == CH_S) begin
					tok.push_back(CH_QUOTE);
					tok.push_back(esc);
					used = 2;
				end
			end
			// one UTF-8 character, clipped to what is held and to the limit
			if (tok.size() == 0) begin
				n = lead_size(b0);
				if (n > held) n = held;
				if (n >= lim) n = lim - 1;
				for (int i = 0; i < n; i++) tok.push_back(window_bytes[i]);
				used = n;
			end
			foreach (tok[k]) begin
				beat.tok_byte = tok[k];
				beat.tok_last = (k == tok.size() - 1);
				beat.consumed = beat.tok_last ? used[6:0] : 7'd0;
				expected_beats.push_back(beat);
			end
			held = 0;
		endfunction

		function void note_text_beat(input logic [7:0] b, input logic last);
			if (held < WINDOW) begin
				window_bytes[held] = b;
				held++;
			end
			if (last) split_token();
		endfunction

		task check_tok_beat(input logic [7:0] b, input logic last, input logic [6:0] used);
			tok_beat_t exp_beat;
			if (expected_beats.size() == 0) begin
				report_mismatch($sformatf("unexpected token beat byte=%02h last=%b consumed=%0d",
					b, last, used));
			end else begin
				exp_beat = expected_beats.pop_front();
				if (b !== exp_beat.tok_byte)
					report_mismatch($sformatf("tok_byte got %02h exp %02h", b, exp_beat.tok_byte));
				if (last !== exp_beat.tok_last)
					report_mismatch($sformatf("tok_last got %b exp %b", last, exp_beat.tok_last));
				if (used !== exp_beat.consumed)
					report_mismatch($sformatf("consumed got %0d exp %0d", used,
						exp_beat.consumed));
			end
		endtask
	endclass

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic [6:0] cfg_wdata;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] in_byte;
	logic       in_last;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] tok_byte;
	logic       tok_last;
	logic [6:0] consumed;

	token_scoreboard sb = new();

	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned beats_sent     = 0;
	bit          pressure_req   = 1'b0;
	bit          pressure_done  = 1'b0;

	charset_token_splitter_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.tok_byte  (tok_byte),
		.tok_last  (tok_last),
		.consumed  (consumed)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Watch both channels; predict on input beats, check output beats
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (in_valid && in_ready) sb.note_text_beat(in_byte, in_last);
			if (out_valid && out_ready) sb.check_tok_beat(tok_byte, tok_last, consumed);
		end
	end

	// Output side: random stalls, plus one long hold-off on request
	initial begin : receiver
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (pressure_req && !pressure_done) begin
				out_ready <= 1'b0;
				for (int i = 0; i < PRESSURE_CYCLES; i++) @(posedge clk);
				pressure_done = 1'b1;
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Offer one text beat and hold it until accepted
	task send_beat(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		in_last  <= last;
		do @(posedge clk); while (!in_ready);
		beats_sent++;
	endtask

	task send_text(input text_t t);
		foreach (t[i]) send_beat(t[i], i == t.size() - 1);
	endtask

	// Drop valid, let the monitor see the closing beat, then wait for every token beat
	task finish_phase();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task write_limit(input logic [6:0] v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_limit(v);
	endtask

	// Random byte biased toward the marks the splitter cares about
	function automatic logic [7:0] text_byte();
		logic [7:0] marks[12];
		marks = '{CH_LT, CH_GT, CH_LBRK, CH_RBRK, CH_BSL, CH_QUOTE,
		          CH_S, CH_T, CH_N, CH_R, CH_D, CH_L};
		if ($urandom_range(3) == 0) return marks[$urandom_range(11)];
		return 8'($urandom_range(255));
	endfunction

	// Build one window: mostly well-formed token starts, some noise
	function automatic text_t build_window();
		text_t      t;
		logic [7:0] lead, open_mark, close_mark;
		logic [7:0] esc_set[6];
		logic [7:0] quote_set[5];
		int         inner;
		esc_set   = '{CH_S, CH_T, CH_N, CH_R, CH_BSL, 8'h00};
		quote_set = '{CH_R, CH_D, CH_L, CH_S, 8'h00};
		case ($urandom_range(7))
			0, 1: begin
				open_mark  = $urandom_range(1) ? CH_LT : CH_LBRK;
				close_mark = (open_mark == CH_LT) ? CH_GT : CH_RBRK;
				inner = ($urandom_range(7) == 0) ? $urandom_range(10, 62) : $urandom_range(6);
				t.push_back(open_mark);
				repeat (inner) t.push_back(text_byte());
				if ($urandom_range(99) < 85) t.push_back(close_mark);
			end
			2: begin
				t.push_back(CH_BSL);
				if ($urandom_range(6) != 0) begin
					esc_set[5] = text_byte();
					t.push_back(esc_set[$urandom_range(5)]);
				end
			end
			3: begin
				t.push_back(CH_QUOTE);
				if ($urandom_range(6) != 0) begin
					quote_set[4] = text_byte();
					t.push_back(quote_set[$urandom_range(4)]);
				end
			end
			4, 5: begin
				case ($urandom_range(5))
					0:       lead = 8'($urandom_range(8'h00, 8'h7F));
					1:       lead = 8'($urandom_range(8'hC0, 8'hDF));
					2:       lead = 8'($urandom_range(8'hE0, 8'hEF));
					3:       lead = 8'($urandom_range(8'hF0, 8'hF7));
					4:       lead = 8'($urandom_range(8'hF8, 8'hFF));
					default: lead = 8'($urandom_range(8'h80, 8'hBF));
				endcase
				t.push_back(lead);
				repeat ($urandom_range(4)) t.push_back({2'b10, 6'($urandom_range(63))});
			end
			default: begin
				repeat ($urandom_range(1, 8)) t.push_back(8'($urandom_range(255)));
			end
		endcase
		repeat ($urandom_range(3)) t.push_back(text_byte());
		return t;
	endfunction

	initial begin : stimulus
		text_t       t;
		logic [6:0]  phase_limit;
		int unsigned start_count;
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_wdata <= '0;
		in_valid  <= 1'b0;
		in_byte   <= '0;
		in_last   <= 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed tokens under the reset limit
		send_text('{CH_LT, 8'h61, CH_GT});
		send_text('{CH_LBRK, 8'h00, 8'hFF, CH_RBRK});
		send_text('{CH_BSL, CH_S});
		send_text('{CH_BSL, CH_N});
		send_text('{CH_BSL, CH_BSL});
		send_text('{CH_BSL, 8'h71});
		send_text('{CH_BSL});
		send_text('{CH_QUOTE, CH_D});
		send_text('{CH_QUOTE, 8'h78});
		send_text('{8'hF0, 8'h9F, 8'h98, 8'h80});
		send_text('{8'hE2, 8'h82});
		send_text('{8'hFF});
		finish_phase();

		// Random phases across limit settings and idle patterns
		for (int p = 0; p < PHASE_COUNT; p++) begin
			case (p)
				0:       phase_limit = 7'd127;
				1:       phase_limit = LIMIT_MIN;
				2:       phase_limit = 7'd0;
				3:       phase_limit = 7'd3;
				4:       phase_limit = 7'd66;
				5:       phase_limit = 7'd1;
				6:       phase_limit = LIMIT_MAX;
				default: phase_limit = 7'($urandom_range(127));
			endcase
			write_limit(phase_limit);
			case (p % 4)
				0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1:       begin send_idle_pct = 79; recv_stall_pct = 0;  end
				2:       begin send_idle_pct = 0;  recv_stall_pct = 79; end
				default: begin send_idle_pct = 24; recv_stall_pct = 24; end
			endcase
			if (p == PRESSURE_PHASE) pressure_req = 1'b1;
			// Full window: widest group, then bytes past the end
			if (p == LONG_PHASE) begin
				t = {};
				t.push_back(CH_LT);
				while (t.size() < WINDOW - 1) begin
					t.push_back(text_byte());
					if (t[t.size() - 1] == CH_GT) void'(t.pop_back());
				end
				t.push_back(CH_GT);
				repeat (4) t.push_back(text_byte());
				send_text(t);
			end
			start_count = beats_sent;
			while (beats_sent - start_count < PHASE_ITEMS) send_text(build_window());
			finish_phase();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.pending() != 0)
			sb.report_mismatch($sformatf("%0d token beats never arrived", sb.pending()));
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
